// File: src/dsc_pkg.sv
// Shared types, constants and helper functions of the drowsiness status classifier.
package dsc_pkg;

  localparam int CoordBitsDef = 15;
  localparam int InCoordW     = 15;
  localparam int NumPoints    = 20;
  localparam int PidxW        = 5;
  localparam int NumDist      = 10;
  localparam int SelW         = 4;
  localparam int RatioW       = 18;
  localparam int FracBits     = 16;
  localparam int AngleW       = 17;
  localparam int LimitW       = 16;
  localparam int TimeW        = 32;
  localparam int BlinkW       = 16;
  localparam int StatusW      = 3;
  localparam int CfgAddrW     = 3;
  localparam int CfgDataW     = 18;
  localparam int InTdataW     = 104;
  localparam int OutTdataW    = 56;

  localparam logic [RatioW-1:0] RatioMax = '1;
  localparam logic [BlinkW-1:0] BlinkMax = '1;

  localparam logic [RatioW-1:0] EarThrRst   = 18'd16384;
  localparam logic [RatioW-1:0] MarThrRst   = 18'd42598;
  localparam logic [LimitW-1:0] ClosedMsRst = 16'd1000;
  localparam logic [LimitW-1:0] YawLimRst   = 16'd6400;
  localparam logic [LimitW-1:0] PitchLimRst = 16'd5120;

  // Ceil to whole seconds: (t + 999) * Recip >> RecipShift is floor(x / 1000) here.
  localparam logic [16:0] SecRound   = 17'd999;
  localparam logic [16:0] Recip      = 17'd67109;
  localparam int          RecipShift = 26;
  localparam logic [16:0] MsPerSec   = 17'd1000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_EAR_THR   = 3'd0,
    CFG_MAR_THR   = 3'd1,
    CFG_CLOSED_MS = 3'd2,
    CFG_YAW_LIM   = 3'd3,
    CFG_PITCH_LIM = 3'd4
  } cfg_idx_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_YAWN     = 3'd2,
    ST_LEFT     = 3'd3,
    ST_RIGHT    = 3'd4,
    ST_DOWN     = 3'd5,
    ST_NO_LMARK = 3'd6,
    ST_NO_FACE  = 3'd7
  } status_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CHK  = 9'b000000010,
    S_RD   = 9'b000000100,
    S_SQ   = 9'b000001000,
    S_RTI  = 9'b000010000,
    S_ROOT = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_DIVW = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic            pt_wr;
    logic            frame_ld;
    logic            rd_go;
    logic            sq_go;
    logic            root_go;
    logic            div_go;
    logic            decide;
    logic [SelW-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic root_done;
    logic div_done;
    logic out_free;
  } stat_t;

  // Landmark pairs, distances 0-2 left eye, 3-5 right eye, 6-9 mouth.
  function automatic logic [PidxW-1:0] pair_a(input logic [SelW-1:0] sel);
    logic [PidxW-1:0] r;
    case (sel)
      4'd0:    r = 5'd1;
      4'd1:    r = 5'd2;
      4'd2:    r = 5'd0;
      4'd3:    r = 5'd7;
      4'd4:    r = 5'd8;
      4'd5:    r = 5'd6;
      4'd6:    r = 5'd13;
      4'd7:    r = 5'd14;
      4'd8:    r = 5'd15;
      default: r = 5'd12;
    endcase
    return r;
  endfunction

  function automatic logic [PidxW-1:0] pair_b(input logic [SelW-1:0] sel);
    logic [PidxW-1:0] r;
    case (sel)
      4'd0:    r = 5'd5;
      4'd1:    r = 5'd4;
      4'd2:    r = 5'd3;
      4'd3:    r = 5'd11;
      4'd4:    r = 5'd10;
      4'd5:    r = 5'd9;
      4'd6:    r = 5'd19;
      4'd7:    r = 5'd18;
      4'd8:    r = 5'd17;
      default: r = 5'd16;
    endcase
    return r;
  endfunction

endpackage

// File: src/dsc_ctrl.sv
// Sequencing state machine of the drowsiness status classifier.
module dsc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tuser,
  output logic           in_tready,
  input  dsc_pkg::stat_t st,
  output dsc_pkg::cmd_t  cmd
);
  import dsc_pkg::*;

  localparam logic [SelW-1:0] LastDist = SelW'(NumDist - 1);
  localparam logic [SelW-1:0] LastDiv  = 4'd2;

  state_t          state_r, state_nxt;
  logic [SelW-1:0] sel_r, sel_nxt;
  logic            accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    cmd          = '0;
    cmd.sel      = sel_r;
    cmd.pt_wr    = accept && !in_tuser;
    cmd.frame_ld = accept && in_tuser;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_tuser) state_nxt = S_CHK;
      end
      S_CHK: begin
        sel_nxt   = '0;
        state_nxt = st.frame_ok ? S_RD : S_OUT;
      end
      S_RD: begin
        cmd.rd_go = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq_go = 1'b1;
        state_nxt = S_RTI;
      end
      S_RTI: begin
        cmd.root_go = 1'b1;
        state_nxt   = S_ROOT;
      end
      S_ROOT: begin
        if (st.root_done) begin
          if (sel_r == LastDist) begin
            sel_nxt   = '0;
            state_nxt = S_DIV;
          end else begin
            sel_nxt   = sel_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_DIV: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVW;
      end
      S_DIVW: begin
        if (st.div_done) begin
          if (sel_r == LastDiv) begin
            state_nxt = S_OUT;
          end else begin
            sel_nxt   = sel_r + 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.decide = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

// File: src/dsc_dp.sv
// Datapath: landmark memory, distance root unit, ratio divider and status decision.
module dsc_dp #(
  parameter int COORD_BITS = dsc_pkg::CoordBitsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dsc_pkg::cmd_t                    cmd,
  output dsc_pkg::stat_t                   st,
  input  logic                             cfg_we,
  input  logic [dsc_pkg::CfgAddrW-1:0]     cfg_addr,
  input  logic [dsc_pkg::CfgDataW-1:0]     cfg_wdata,
  input  logic [dsc_pkg::PidxW-1:0]        point_index,
  input  logic [dsc_pkg::InCoordW-1:0]     point_x,
  input  logic [dsc_pkg::InCoordW-1:0]     point_y,
  input  logic                             face_found,
  input  logic                             landmarks_found,
  input  logic signed [dsc_pkg::AngleW-1:0] pitch_angle,
  input  logic signed [dsc_pkg::AngleW-1:0] yaw_angle,
  input  logic [dsc_pkg::TimeW-1:0]        frame_time_ms,
  input  logic                             out_tready,
  output logic                             out_valid,
  output logic [dsc_pkg::StatusW-1:0]      status_code,
  output logic [dsc_pkg::BlinkW-1:0]       blink_total,
  output logic [dsc_pkg::RatioW-1:0]       eye_ratio,
  output logic [dsc_pkg::RatioW-1:0]       mouth_ratio
);
  import dsc_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int RW   = 2 * CB + 18;
  localparam int DW   = RW / 2;
  localparam int NUMW = DW + 2;
  localparam int DENW = DW + 2;
  localparam int RCW  = $clog2(DW + 1);
  localparam logic [RCW-1:0] RootLast = RCW'(DW - 1);
  localparam logic [4:0]     DivLast  = 5'(RatioW - 1);

  // Configuration registers.
  logic [RatioW-1:0] ear_thr_r, mar_thr_r;
  logic [LimitW-1:0] closed_ms_r, yaw_lim_r, pitch_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ear_thr_r   <= EarThrRst;
      mar_thr_r   <= MarThrRst;
      closed_ms_r <= ClosedMsRst;
      yaw_lim_r   <= YawLimRst;
      pitch_lim_r <= PitchLimRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_EAR_THR:   ear_thr_r   <= cfg_wdata;
        CFG_MAR_THR:   mar_thr_r   <= cfg_wdata;
        CFG_CLOSED_MS: closed_ms_r <= cfg_wdata[LimitW-1:0];
        CFG_YAW_LIM:   yaw_lim_r   <= cfg_wdata[LimitW-1:0];
        CFG_PITCH_LIM: pitch_lim_r <= cfg_wdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Closure time rounded up to whole seconds, kept up to date from the register.
  logic [33:0] sec_prod;
  logic [6:0]  sec_r;
  logic [16:0] thr_ms_r;
  assign sec_prod = 34'({1'b0, closed_ms_r} + SecRound) * 34'(Recip);
  always_ff @(posedge clk) begin
    sec_r    <= sec_prod[RecipShift+6:RecipShift];
    thr_ms_r <= 17'(17'(sec_r) * MsPerSec);
  end

  // Landmark memory, {y, x} per entry.
  logic [2*CB-1:0] mem [NumPoints];
  logic [2*CB-1:0] rda_r, rdb_r;
  always_ff @(posedge clk) begin
    if (cmd.pt_wr && (point_index < PidxW'(NumPoints)))
      mem[point_index] <= {CB'(point_y), CB'(point_x)};
    if (cmd.rd_go) begin
      rda_r <= mem[pair_a(cmd.sel)];
      rdb_r <= mem[pair_b(cmd.sel)];
    end
  end

  // Squared distance.
  logic [CB-1:0]   ax, ay, bx, by, dx, dy;
  logic [2*CB:0]   sum_r;
  assign ax = rda_r[CB-1:0];
  assign ay = rda_r[2*CB-1:CB];
  assign bx = rdb_r[CB-1:0];
  assign by = rdb_r[2*CB-1:CB];
  assign dx = (ax > bx) ? ax - bx : bx - ax;
  assign dy = (ay > by) ? ay - by : by - ay;
  always_ff @(posedge clk) begin
    if (cmd.sq_go) sum_r <= (2*CB+1)'(dx * dx) + (2*CB+1)'(dy * dy);
  end

  // Bit-by-bit square root, one result bit per cycle.
  logic [RW-1:0]  v_r, res_r, bit_r, trial;
  logic [RW-1:0]  v_nxt, res_nxt;
  logic [RCW-1:0] rcnt_r;
  logic           root_busy_r;
  logic [DW-1:0]  dist_r [NumDist];

  assign trial = res_r + bit_r;
  always_comb begin
    if (v_r >= trial) begin
      v_nxt   = v_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      v_nxt   = v_r;
      res_nxt = res_r >> 1;
    end
  end
  assign st.root_done = root_busy_r && (rcnt_r == RootLast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_busy_r <= 1'b0;
    end else if (cmd.root_go) begin
      root_busy_r <= 1'b1;
    end else if (st.root_done) begin
      root_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_go) begin
      v_r    <= RW'({sum_r, 16'b0});
      res_r  <= '0;
      bit_r  <= RW'(1) << (RW - 2);
      rcnt_r <= '0;
    end else if (root_busy_r) begin
      v_r    <= v_nxt;
      res_r  <= res_nxt;
      bit_r  <= bit_r >> 2;
      rcnt_r <= rcnt_r + 1'b1;
      if (st.root_done) dist_r[cmd.sel] <= res_nxt[DW-1:0];
    end
  end

  // Ratio divider: restoring, one quotient bit per cycle, saturating.
  logic [NUMW-1:0] num;
  logic [DENW-1:0] den;
  logic [DENW:0]   rem_r, rtrial;
  logic [RatioW-1:0] nsh_r, q_r, q_nxt;
  logic [4:0]      dcnt_r;
  logic            div_busy_r, sat_r;
  logic [RatioW-1:0] ratio_r [3];

  always_comb begin
    case (cmd.sel)
      4'd0: begin
        num = NUMW'(dist_r[0]) + NUMW'(dist_r[1]);
        den = DENW'({dist_r[2], 1'b0});
      end
      4'd1: begin
        num = NUMW'(dist_r[3]) + NUMW'(dist_r[4]);
        den = DENW'({dist_r[5], 1'b0});
      end
      default: begin
        num = NUMW'(dist_r[6]) + NUMW'(dist_r[7]) + NUMW'(dist_r[8]);
        den = DENW'(dist_r[9]) + DENW'({dist_r[9], 1'b0});
      end
    endcase
  end

  assign rtrial = {rem_r[DENW-1:0], nsh_r[RatioW-1]};
  always_comb begin
    if (rtrial >= (DENW+1)'(den)) q_nxt = {q_r[RatioW-2:0], 1'b1};
    else                          q_nxt = {q_r[RatioW-2:0], 1'b0};
  end
  assign st.div_done = div_busy_r && (dcnt_r == DivLast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_go) begin
      div_busy_r <= 1'b1;
    end else if (st.div_done) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      // Quotient needs more than 18 bits when num >= 4 * den.
      sat_r  <= (den == '0) || ((NUMW+2)'(num) >= {den, 2'b0});
      rem_r  <= (DENW+1)'(num >> 2);
      nsh_r  <= {num[1:0], 16'b0};
      q_r    <= '0;
      dcnt_r <= '0;
    end else if (div_busy_r) begin
      rem_r  <= (rtrial >= (DENW+1)'(den)) ? rtrial - (DENW+1)'(den) : rtrial;
      nsh_r  <= nsh_r << 1;
      q_r    <= q_nxt;
      dcnt_r <= dcnt_r + 1'b1;
      if (st.div_done) ratio_r[cmd.sel[1:0]] <= sat_r ? RatioMax : q_nxt;
    end
  end

  // Frame-end fields.
  logic                     face_r, lmark_r;
  logic signed [AngleW-1:0] pitch_r, yaw_r;
  logic [TimeW-1:0]         now_r;
  always_ff @(posedge clk) begin
    if (cmd.frame_ld) begin
      face_r  <= face_found;
      lmark_r <= landmarks_found;
      pitch_r <= pitch_angle;
      yaw_r   <= yaw_angle;
      now_r   <= frame_time_ms;
    end
  end
  assign st.frame_ok = face_r && lmark_r;

  // Decision and closure tracking.
  logic              eyes_shut_r;
  logic [TimeW-1:0]  shut_since_r, elapsed;
  logic [BlinkW-1:0] blink_r;
  logic [RatioW:0]   ear_sum;
  logic [RatioW-1:0] ear;
  logic              closed, alert;
  logic signed [AngleW:0] yaw_ext, pitch_ext, ylim, plim;
  status_t           status;

  assign ear_sum   = {1'b0, ratio_r[0]} + {1'b0, ratio_r[1]};
  assign ear       = ear_sum[RatioW:1];
  assign closed    = ear < ear_thr_r;
  assign elapsed   = now_r - shut_since_r;
  assign alert     = elapsed >= TimeW'(thr_ms_r);
  assign yaw_ext   = {yaw_r[AngleW-1], yaw_r};
  assign pitch_ext = {pitch_r[AngleW-1], pitch_r};
  assign ylim      = {2'b00, yaw_lim_r};
  assign plim      = {2'b00, pitch_lim_r};

  always_comb begin
    status = ST_OK;
    if (!face_r) begin
      status = ST_NO_FACE;
    end else if (!lmark_r) begin
      status = ST_NO_LMARK;
    end else begin
      if (closed && eyes_shut_r && alert) status = ST_CLOSED;
      if (ratio_r[2] > mar_thr_r)         status = ST_YAWN;
      if (yaw_ext > ylim)                 status = ST_LEFT;
      else if (yaw_ext < -ylim)           status = ST_RIGHT;
      else if (pitch_ext > plim)          status = ST_DOWN;
    end
  end

  logic [BlinkW-1:0] blink_nxt;
  always_comb begin
    blink_nxt = blink_r;
    if (st.frame_ok && !closed && eyes_shut_r && (blink_r != BlinkMax))
      blink_nxt = blink_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eyes_shut_r  <= 1'b0;
      shut_since_r <= '0;
      blink_r      <= '0;
    end else if (cmd.decide && st.frame_ok) begin
      blink_r <= blink_nxt;
      if (closed) begin
        if (!eyes_shut_r) begin
          shut_since_r <= now_r;
          eyes_shut_r  <= 1'b1;
        end
      end else begin
        eyes_shut_r <= 1'b0;
      end
    end
  end

  // Output register.
  logic out_valid_r;
  assign st.out_free = !out_valid_r || out_tready;
  assign out_valid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.decide) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      status_code <= status;
      blink_total <= blink_nxt;
      eye_ratio   <= st.frame_ok ? ear : '0;
      mouth_ratio <= st.frame_ok ? ratio_r[2] : '0;
    end
  end

endmodule

// File: src/drowsiness_status_classifier_unit.sv
// A landmark beat is written to the landmark memory when accepted; a frame-end beat gives
// its result after the ten distances, the three ratios and a free output register.
// Throughput: one landmark beat per cycle while idle; frame-end beats one at a time, set
// by the shared one-bit-per-cycle square root unit (ten distances) and the 18-step divider.
// Reset (synchronous, rst_n low) restores the threshold registers, clears the eye
// closure state and blink count and empties the output register.
module drowsiness_status_classifier_unit #(
  parameter int COORD_BITS = dsc_pkg::CoordBitsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: point_index, point_x, point_y, face_found, landmarks_found,
  //        pitch_angle, yaw_angle, frame_time_ms, zero pad
  input  logic [dsc_pkg::InTdataW-1:0]    in_tdata,
  // tuser: kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: status_code, blink_total, eye_ratio, mouth_ratio, zero pad
  output logic [dsc_pkg::OutTdataW-1:0]   out_tdata,
  input  logic                            cfg_we,
  input  logic [dsc_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [dsc_pkg::CfgDataW-1:0]    cfg_wdata
);
  import dsc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  logic [StatusW-1:0] status_code;
  logic [BlinkW-1:0]  blink_total;
  logic [RatioW-1:0]  eye_ratio, mouth_ratio;

  dsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  dsc_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .point_index     (in_tdata[4:0]),
    .point_x         (in_tdata[19:5]),
    .point_y         (in_tdata[34:20]),
    .face_found      (in_tdata[35]),
    .landmarks_found (in_tdata[36]),
    .pitch_angle     (in_tdata[53:37]),
    .yaw_angle       (in_tdata[70:54]),
    .frame_time_ms   (in_tdata[102:71]),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .status_code     (status_code),
    .blink_total     (blink_total),
    .eye_ratio       (eye_ratio),
    .mouth_ratio     (mouth_ratio)
  );

  assign out_tdata = {1'b0, mouth_ratio, eye_ratio, blink_total, status_code};

endmodule

// File: src/dsc_checker.sv
// Port-level checks of the drowsiness status classifier, bound to the top level.
module dsc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [dsc_pkg::OutTdataW-1:0] out_tdata
);
  import dsc_pkg::*;

  logic fr_acc, pt_acc, no_det;
  assign fr_acc = in_tvalid && in_tready && in_tuser;
  assign pt_acc = in_tvalid && in_tready && !in_tuser;
  assign no_det = (out_tdata[2:0] == ST_NO_FACE) || (out_tdata[2:0] == ST_NO_LMARK);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fr_acc |=> !in_tready)
    else $error("input taken while a frame is being evaluated");

  a_point: assert property (@(posedge clk) disable iff (!rst_n)
    pt_acc |=> !$rose(out_tvalid))
    else $error("result raised by a landmark beat");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && no_det |-> out_tdata[54:19] == '0)
    else $error("ratios nonzero without detection");

endmodule

bind drowsiness_status_classifier_unit dsc_checker u_dsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/tb.sv
// Testbench for the drowsiness status classifier: directed table plus random frames.
`timescale 1ns / 1ps

module tb;
  import dsc_pkg::*;

  typedef struct {
    logic                kind;
    logic [4:0]          idx;
    logic [14:0]         x;
    logic [14:0]         y;
    logic                face;
    logic                lmk;
    logic signed [16:0]  pitch;
    logic signed [16:0]  yaw;
    logic [31:0]         tm;
    bit                  typed;
    logic [StatusW-1:0]  t_status;
    logic [BlinkW-1:0]   t_blink;
    logic [RatioW-1:0]   t_eye;
    logic [RatioW-1:0]   t_mouth;
  } beat_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [BlinkW-1:0]  blink;
    logic [RatioW-1:0]  eye;
    logic [RatioW-1:0]  mouth;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InTdataW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  drowsiness_status_classifier_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the classifier.
  logic [RatioW-1:0] m_ear_thr = EarThrRst;
  logic [RatioW-1:0] m_mar_thr = MarThrRst;
  logic [LimitW-1:0] m_closed_ms = ClosedMsRst;
  logic [LimitW-1:0] m_yaw_lim = YawLimRst;
  logic [LimitW-1:0] m_pitch_lim = PitchLimRst;
  logic [14:0] pts_x [NumPoints];
  logic [14:0] pts_y [NumPoints];
  bit m_shut = 0;
  logic [31:0] m_shut_since = '0;
  logic [BlinkW-1:0] m_blinks = '0;

  verdict_t pending_q[$];
  beat_t table_q[$];
  int errors = 0;
  int tx_idle_pct = 29;
  int rx_idle_pct = 84;
  bit eyes_closing = 0;
  logic [31:0] clock_ms = '0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned span(int a, int b);
    longint unsigned dx, dy;
    dx = pts_x[a] > pts_x[b] ? pts_x[a] - pts_x[b] : pts_x[b] - pts_x[a];
    dy = pts_y[a] > pts_y[b] ? pts_y[a] - pts_y[b] : pts_y[b] - pts_y[a];
    return int_sqrt((dx * dx + dy * dy) << 16);
  endfunction

  function automatic logic [RatioW-1:0] sat_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return RatioMax;
    q = (num << 16) / den;
    return q > RatioMax ? RatioMax : q[RatioW-1:0];
  endfunction

  function automatic logic [RatioW-1:0] eye_open_ratio(int base);
    return sat_ratio(span(base + 1, base + 5) + span(base + 2, base + 4),
                     2 * span(base, base + 3));
  endfunction

  // Updates the model state; returns 1 when the beat yields a status beat.
  function automatic bit classify(input beat_t b, output verdict_t v);
    logic [31:0] elapsed, whole;
    logic [18:0] ear_sum;
    status_t st;
    v = '{default: '0};
    if (!b.kind) begin
      if (b.idx < NumPoints) begin
        pts_x[b.idx] = b.x;
        pts_y[b.idx] = b.y;
      end
      return 0;
    end
    if (!b.face) st = ST_NO_FACE;
    else if (!b.lmk) st = ST_NO_LMARK;
    else begin
      ear_sum = eye_open_ratio(0) + eye_open_ratio(6);
      v.eye = ear_sum[18:1];
      v.mouth = sat_ratio(span(13, 19) + span(14, 18) + span(15, 17), 3 * span(12, 16));
      st = ST_OK;
      if (v.eye < m_ear_thr) begin
        if (!m_shut) begin
          m_shut_since = b.tm;
          m_shut = 1;
        end else begin
          elapsed = b.tm - m_shut_since;
          whole = elapsed - elapsed % 1000;
          if (whole >= m_closed_ms) st = ST_CLOSED;
        end
      end else if (m_shut) begin
        if (m_blinks != BlinkMax) m_blinks = m_blinks + 1'b1;
        m_shut = 0;
      end
      if (v.mouth > m_mar_thr) st = ST_YAWN;
      if (b.yaw > $signed({1'b0, m_yaw_lim})) st = ST_LEFT;
      else if (b.yaw < -$signed({1'b0, m_yaw_lim})) st = ST_RIGHT;
      else if (b.pitch > $signed({1'b0, m_pitch_lim})) st = ST_DOWN;
    end
    v.status = st;
    v.blink = m_blinks;
    return 1;
  endfunction

  // Valid stays high after the accepting edge; the next beat or an idle cycle replaces it.
  task automatic send(input beat_t b);
    verdict_t v;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= b.kind;
    in_tdata <= {1'b0, b.tm, b.yaw, b.pitch, b.lmk, b.face, b.y, b.x, b.idx};
    do @(posedge clk); while (!in_tready);
    if (classify(b, v)) begin
      if (b.typed) v = '{b.t_status, b.t_blink, b.t_eye, b.t_mouth};
      pending_q.push_back(v);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_EAR_THR:   m_ear_thr = val;
      CFG_MAR_THR:   m_mar_thr = val;
      CFG_CLOSED_MS: m_closed_ms = val[LimitW-1:0];
      CFG_YAW_LIM:   m_yaw_lim = val[LimitW-1:0];
      default:       m_pitch_lim = val[LimitW-1:0];
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic beat_t point(int idx, int x, int y);
    beat_t b = '{default: '0};
    b.idx = idx;
    b.x = x;
    b.y = y;
    return b;
  endfunction

  function automatic beat_t frame_end(bit face, bit lmk, int pitch, int yaw, logic [31:0] tm);
    beat_t b = '{default: '0};
    b.kind = 1'b1;
    b.face = face;
    b.lmk = lmk;
    b.pitch = pitch;
    b.yaw = yaw;
    b.tm = tm;
    return b;
  endfunction

  function automatic beat_t typed_end(beat_t b, status_t st, int blink, int eye, int mouth);
    b.typed = 1;
    b.t_status = st;
    b.t_blink = blink;
    b.t_eye = eye;
    b.t_mouth = mouth;
    return b;
  endfunction

  // Two eyes and a mouth around random centers, then a frame end; upper/lower pairs differ only vertically.
  task automatic send_frame();
    int w, h, cx, cy, mw, mh, n;
    beat_t b;
    for (int e = 0; e < 2; e++) begin
      w = $urandom_range(16, 2000);
      h = eyes_closing ? $urandom_range(0, w / 8) : $urandom_range(w / 8, w);
      cx = $urandom_range(2100, 30600);
      cy = $urandom_range(2100, 30600);
      send(point(6 * e + 0, cx - w, cy));
      send(point(6 * e + 3, cx + w, cy));
      send(point(6 * e + 1, cx - w / 3, cy - h));
      send(point(6 * e + 5, cx - w / 3, cy + h));
      send(point(6 * e + 2, cx + w / 3, cy - h));
      send(point(6 * e + 4, cx + w / 3, cy + h));
    end
    mw = $urandom_range(0, 2000);
    mh = $urandom_range(0, 2000);
    cx = $urandom_range(2100, 30600);
    cy = $urandom_range(2100, 30600);
    send(point(12, cx - mw, cy));
    send(point(16, cx + mw, cy));
    for (int k = 0; k < 3; k++) begin
      send(point(13 + k, cx - mw / 2 + k * mw / 2, cy - mh));
      send(point(19 - k, cx - mw / 2 + k * mw / 2, cy + mh + $urandom_range(0, 3)));
    end
    n = $urandom_range(0, 9);
    if (n == 0) send(point($urandom_range(20, 31), $urandom_range(0, 32767),
                            $urandom_range(0, 32767)));
    if (n == 1) send(point($urandom_range(0, 19), $urandom_range(0, 32767),
                            $urandom_range(0, 32767)));
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 1500);
    if ($urandom_range(0, 9) < 3) eyes_closing = !eyes_closing;
    b = frame_end($urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0,
                  $urandom_range(0, 4) == 0 ? $signed($urandom_range(0, 92160)) - 46080
                                            : $signed($urandom_range(0, 12000)) - 6000,
                  $urandom_range(0, 4) == 0 ? $signed($urandom_range(0, 92160)) - 46080
                                            : $signed($urandom_range(0, 16000)) - 8000,
                  clock_ms);
    send(b);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected status beat %h", out_tdata);
      end else begin
        want = pending_q.pop_front();
        if (out_tdata[2:0] !== want.status || out_tdata[18:3] !== want.blink ||
            out_tdata[36:19] !== want.eye || out_tdata[54:37] !== want.mouth) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d blk=%0d ear=%0d mar=%0d got st=%0d blk=%0d ear=%0d mar=%0d",
                     want.status, want.blink, want.eye, want.mouth, out_tdata[2:0],
                     out_tdata[18:3], out_tdata[36:19], out_tdata[54:37]);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int sent;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: missing face and landmarks first, then degenerate all-equal points.
    table_q.push_back(typed_end(frame_end(0, 1, 0, 0, 0), ST_NO_FACE, 0, 0, 0));
    table_q.push_back(typed_end(frame_end(1, 0, 0, 0, 0), ST_NO_LMARK, 0, 0, 0));
    for (int i = 0; i < NumPoints; i++) table_q.push_back(point(i, 32767, 0));
    table_q.push_back(typed_end(frame_end(1, 1, 0, 0, 32'hFFFF_FFFF), ST_YAWN, 0,
                                RatioMax, RatioMax));
    table_q.push_back(typed_end(frame_end(1, 1, 0, 46080, 5), ST_LEFT, 0, RatioMax, RatioMax));
    table_q.push_back(typed_end(frame_end(1, 1, 0, -46080, 9), ST_RIGHT, 0,
                                RatioMax, RatioMax));
    table_q.push_back(typed_end(frame_end(1, 1, 46080, 0, 9), ST_DOWN, 0, RatioMax, RatioMax));
    table_q.push_back(point(31, 0, 32767));
    table_q.push_back(typed_end(frame_end(1, 1, -46080, 0, 9), ST_YAWN, 0,
                                RatioMax, RatioMax));
    foreach (table_q[i]) send(table_q[i]);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0:       begin tx_idle_pct = 29; rx_idle_pct = 84; end
        1:       begin tx_idle_pct = 84; rx_idle_pct = 29; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      if (p == 0) begin
        write_reg(CFG_EAR_THR, 0);
        write_reg(CFG_MAR_THR, 0);
        write_reg(CFG_CLOSED_MS, 0);
        write_reg(CFG_YAW_LIM, 0);
        write_reg(CFG_PITCH_LIM, 0);
      end else if (p == 1) begin
        write_reg(CFG_EAR_THR, 18'h3FFFF);
        write_reg(CFG_MAR_THR, 18'h3FFFF);
        write_reg(CFG_CLOSED_MS, 16'hFFFF);
        write_reg(CFG_YAW_LIM, 46080);
        write_reg(CFG_PITCH_LIM, 46080);
      end else begin
        write_reg(CFG_EAR_THR, $urandom_range(4000, 30000));
        write_reg(CFG_MAR_THR, $urandom_range(10000, 80000));
        write_reg(CFG_CLOSED_MS, 1000 * $urandom_range(0, 3));
        write_reg(CFG_YAW_LIM, $urandom_range(0, 10000));
        write_reg(CFG_PITCH_LIM, $urandom_range(0, 8000));
      end
      sent = 0;
      while (sent < 255) begin
        send_frame();
        sent += 21;
        // Occasionally hold off until the block has delivered everything.
        if ($urandom_range(0, 7) == 0) begin
          in_tvalid <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    for (int i = 0; i < NumPoints; i++) begin
      pts_x[i] = '0;
      pts_y[i] = '0;
    end
  end
endmodule
